// ===== src/rpi_pkg.sv =====
// shared widths, register indexes and word types for the ray/plane unit
package rpi_pkg;

   localparam int CW = 32;            // coordinate width
   localparam int FB = 16;            // fraction bits
   localparam int PW = 2 * CW;        // one product
   localparam int DW = PW + 2;        // dot product of three
   localparam int SW = PW + 3;        // dot product plus shifted offset
   localparam int NW = SW + FB;       // dividend
   localparam int XW = DW + CW + 1;   // divider partial remainder
   localparam int HW = PW - FB + 1;   // hit coordinate before clamping
   localparam int IW = 3;             // register index width

   localparam logic [IW-1:0] REG_NORMAL_X  = 3'd0;
   localparam logic [IW-1:0] REG_NORMAL_Y  = 3'd1;
   localparam logic [IW-1:0] REG_NORMAL_Z  = 3'd2;
   localparam logic [IW-1:0] REG_OFFSET_D  = 3'd3;
   localparam logic [IW-1:0] REG_THRESHOLD = 3'd4;

   typedef struct packed {
      logic                 command;
      logic signed [CW-1:0] origin_x;
      logic signed [CW-1:0] origin_y;
      logic signed [CW-1:0] origin_z;
      logic signed [CW-1:0] dir_x;
      logic signed [CW-1:0] dir_y;
      logic signed [CW-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic signed [CW-1:0] hit_x;
      logic signed [CW-1:0] hit_y;
      logic signed [CW-1:0] hit_z;
      logic [CW-2:0]        distance;
      logic                 overflow;
   } rsp_type;

   typedef struct packed {
      req_type       req;
      logic          parallel;
      logic [CW-2:0] distance;
      logic          dist_ov;
   } side_type;

endpackage

// ===== src/rpi_dot.sv =====
// origin.n and dir.n dot products, multiply stage then sum stage
module rpi_dot (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  rpi_pkg::req_type               in_req,
   input  logic signed [rpi_pkg::CW-1:0]  normal_x,
   input  logic signed [rpi_pkg::CW-1:0]  normal_y,
   input  logic signed [rpi_pkg::CW-1:0]  normal_z,
   output logic                           out_valid,
   output logic signed [rpi_pkg::DW-1:0]  out_pn,
   output logic signed [rpi_pkg::DW-1:0]  out_dn
);
   localparam int PW = rpi_pkg::PW;
   localparam int DW = rpi_pkg::DW;

   logic                 va_ff;
   logic                 vb_ff;
   logic signed [PW-1:0] po_ff [0:2];
   logic signed [PW-1:0] pd_ff [0:2];
   logic signed [DW-1:0] pn_ff;
   logic signed [DW-1:0] dn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      po_ff[0] <= PW'(in_req.origin_x) * PW'(normal_x);
      po_ff[1] <= PW'(in_req.origin_y) * PW'(normal_y);
      po_ff[2] <= PW'(in_req.origin_z) * PW'(normal_z);
      pd_ff[0] <= PW'(in_req.dir_x) * PW'(normal_x);
      pd_ff[1] <= PW'(in_req.dir_y) * PW'(normal_y);
      pd_ff[2] <= PW'(in_req.dir_z) * PW'(normal_z);
      pn_ff    <= DW'(po_ff[0]) + DW'(po_ff[1]) + DW'(po_ff[2]);
      dn_ff    <= DW'(pd_ff[0]) + DW'(pd_ff[1]) + DW'(pd_ff[2]);
   end

   assign out_valid = vb_ff;
   assign out_pn    = pn_ff;
   assign out_dn    = dn_ff;
endmodule

// ===== src/rpi_div.sv =====
// pipelined restoring divider, one quotient bit per stage, signed clamp on exit
module rpi_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [rpi_pkg::NW-1:0]        in_num,
   input  logic [rpi_pkg::DW-1:0]        in_den,
   input  logic                          in_neg,
   output logic                          out_valid,
   output logic signed [rpi_pkg::CW-1:0] out_t,
   output logic                          out_ov
);
   localparam int CW = rpi_pkg::CW;
   localparam int DW = rpi_pkg::DW;
   localparam int XW = rpi_pkg::XW;

   logic          v_ff [0:CW];
   logic [XW-1:0] r_ff [0:CW];
   logic [DW-1:0] d_ff [0:CW];
   logic [CW-1:0] q_ff [0:CW];
   logic          n_ff [0:CW];
   logic          o_ff [0:CW];

   logic                 vo_ff;
   logic signed [CW-1:0] t_ff;
   logic                 ov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   // quotient at or above 2^CW can never fit
   always_ff @(posedge clock) begin
      r_ff[0] <= XW'(in_num);
      d_ff[0] <= in_den;
      q_ff[0] <= '0;
      n_ff[0] <= in_neg;
      o_ff[0] <= XW'(in_num) >= (XW'(in_den) << CW);
   end

   for (genvar k = 0; k < CW; k++) begin : g_stage
      localparam int B = CW - 1 - k;
      logic [XW-1:0] sh;
      logic          ge;

      assign sh = XW'(d_ff[k]) << B;
      assign ge = r_ff[k] >= sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         r_ff[k+1] <= ge ? (r_ff[k] - sh) : r_ff[k];
         q_ff[k+1] <= q_ff[k] | (ge ? (CW'(1) << B) : '0);
         d_ff[k+1] <= d_ff[k];
         n_ff[k+1] <= n_ff[k];
         o_ff[k+1] <= o_ff[k];
      end
   end

   logic [CW-1:0]        qv;
   logic                 ovq;
   logic signed [CW-1:0] tq;

   always_comb begin
      qv  = q_ff[CW];
      ovq = o_ff[CW] || (!n_ff[CW] && qv[CW-1])
            || (n_ff[CW] && qv[CW-1] && (qv[CW-2:0] != '0));
      if (ovq) begin
         tq = n_ff[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
         tq = n_ff[CW] ? -qv : qv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= v_ff[CW];
      end
   end

   always_ff @(posedge clock) begin
      t_ff  <= tq;
      ov_ff <= ovq;
   end

   assign out_valid = vo_ff;
   assign out_t     = t_ff;
   assign out_ov    = ov_ff;
endmodule

// ===== src/rpi_hit.sv =====
// hit point origin + t*dir with clamping, and final result word assembly
module rpi_hit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [rpi_pkg::CW-1:0] in_t,
   input  logic                          in_tov,
   input  rpi_pkg::side_type             in_side,
   output logic                          out_strobe,
   output rpi_pkg::rsp_type              out_rsp
);
   localparam int CW = rpi_pkg::CW;
   localparam int FB = rpi_pkg::FB;
   localparam int PW = rpi_pkg::PW;
   localparam int HW = rpi_pkg::HW;

   logic                 va_ff;
   logic                 vb_ff;
   logic signed [PW-1:0] pr_ff [0:2];
   logic                 tov_ff;
   rpi_pkg::side_type    side_ff;
   rpi_pkg::rsp_type     rsp_ff;
   rpi_pkg::rsp_type     rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      pr_ff[0] <= PW'(in_t) * PW'(in_side.req.dir_x);
      pr_ff[1] <= PW'(in_t) * PW'(in_side.req.dir_y);
      pr_ff[2] <= PW'(in_t) * PW'(in_side.req.dir_z);
      tov_ff   <= in_tov;
      side_ff  <= in_side;
   end

   logic signed [CW-1:0] org [0:2];
   logic signed [HW-1:0] hs  [0:2];
   logic signed [CW-1:0] hc  [0:2];
   logic                 hov [0:2];

   assign org[0] = side_ff.req.origin_x;
   assign org[1] = side_ff.req.origin_y;
   assign org[2] = side_ff.req.origin_z;

   // floor shift of the product, then clamp when the top bits disagree
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hs[k]  = HW'(org[k]) + HW'(pr_ff[k] >>> FB);
         hov[k] = (hs[k][HW-1:CW-1] != '0) && (hs[k][HW-1:CW-1] != '1);
         if (hov[k]) begin
            hc[k] = hs[k][HW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end else begin
            hc[k] = hs[k][CW-1:0];
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      if (side_ff.req.command) begin
         rsp_in.distance = side_ff.distance;
         rsp_in.overflow = side_ff.dist_ov;
      end else if (!side_ff.parallel) begin
         rsp_in.hit      = 1'b1;
         rsp_in.hit_x    = hc[0];
         rsp_in.hit_y    = hc[1];
         rsp_in.hit_z    = hc[2];
         rsp_in.overflow = tov_ff || hov[0] || hov[1] || hov[2];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_strobe = vb_ff;
   assign out_rsp    = rsp_ff;
endmodule

// ===== src/ray_plane_intersect.sv =====
// ray/plane intersection and point/plane distance against one configured plane
// throughput: one word per cycle; a fully pipelined divider, one quotient bit per stage,
// sets the depth, and busy is never raised since the receiver cannot stall
// reset: synchronous, clears all valid bits, normal and offset to zero, threshold to one
module ray_plane_intersect (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  rpi_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output rpi_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rpi_pkg::IW-1:0]        csr_index,
   input  logic [rpi_pkg::CW-1:0]        csr_data
);
   localparam int CW = rpi_pkg::CW;
   localparam int FB = rpi_pkg::FB;
   localparam int DW = rpi_pkg::DW;
   localparam int SW = rpi_pkg::SW;
   localparam int NW = rpi_pkg::NW;

   // configuration
   logic signed [CW-1:0] nx_ff, ny_ff, nz_ff, off_ff;
   logic [CW-2:0]        thr_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff  <= '0;
         ny_ff  <= '0;
         nz_ff  <= '0;
         off_ff <= '0;
         thr_ff <= (CW-1)'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rpi_pkg::REG_NORMAL_X:  nx_ff  <= csr_data;
            rpi_pkg::REG_NORMAL_Y:  ny_ff  <= csr_data;
            rpi_pkg::REG_NORMAL_Z:  nz_ff  <= csr_data;
            rpi_pkg::REG_OFFSET_D:  off_ff <= csr_data;
            rpi_pkg::REG_THRESHOLD: thr_ff <= csr_data[CW-2:0];
            default: ;
         endcase
      end
   end

   // input register
   logic             v0_ff;
   rpi_pkg::req_type req_ff;
   rpi_pkg::req_type rq_ff [0:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      rq_ff[0] <= req_ff;
      rq_ff[1] <= rq_ff[0];
   end

   logic                 dot_valid;
   logic signed [DW-1:0] pn;
   logic signed [DW-1:0] dn;

   rpi_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_req    (req_ff),
      .normal_x  (nx_ff),
      .normal_y  (ny_ff),
      .normal_z  (nz_ff),
      .out_valid (dot_valid),
      .out_pn    (pn),
      .out_dn    (dn)
   );

   // numerator, divisor magnitude, parallel test and distance
   logic signed [SW-1:0] dq;
   logic signed [SW-1:0] dsum;
   logic [SW-1:0]        dabs;
   logic [SW-1:0]        mag;
   logic                 dov;
   logic signed [SW-1:0] diff;
   logic signed [NW-1:0] num;
   logic [NW-1:0]        num_abs;
   logic [DW-1:0]        dn_abs;
   rpi_pkg::side_type    side_in;

   always_comb begin
      dq      = SW'(off_ff) <<< FB;
      dsum    = SW'(pn) + dq;
      dabs    = dsum[SW-1] ? -dsum : dsum;
      mag     = dabs >> FB;
      dov     = mag > ((SW'(1) << (CW-1)) - SW'(1));
      diff    = dq - SW'(pn);
      num     = NW'(diff) <<< FB;
      num_abs = num[NW-1] ? -num : num;
      dn_abs  = dn[DW-1] ? -dn : dn;

      side_in          = '0;
      side_in.req      = rq_ff[1];
      side_in.parallel = dn_abs <= (DW'(thr_ff) << FB);
      side_in.distance = dov ? '1 : mag[CW-2:0];
      side_in.dist_ov  = dov;
   end

   logic              v3_ff;
   logic [NW-1:0]     num3_ff;
   logic [DW-1:0]     den3_ff;
   logic              neg3_ff;
   rpi_pkg::side_type side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= dot_valid;
      end
   end

   always_ff @(posedge clock) begin
      num3_ff  <= num_abs;
      den3_ff  <= dn_abs;
      neg3_ff  <= diff[SW-1] ^ dn[DW-1];
      side3_ff <= side_in;
   end

   logic                 div_valid;
   logic signed [CW-1:0] t;
   logic                 tov;

   rpi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_num    (num3_ff),
      .in_den    (den3_ff),
      .in_neg    (neg3_ff),
      .out_valid (div_valid),
      .out_t     (t),
      .out_ov    (tov)
   );

   // side data rides alongside the divider
   rpi_pkg::side_type sd_ff [0:CW+1];

   always_ff @(posedge clock) begin
      sd_ff[0] <= side3_ff;
      for (int k = 1; k < CW + 2; k++) begin
         sd_ff[k] <= sd_ff[k-1];
      end
   end

   rpi_hit u_hit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_t       (t),
      .in_tov     (tov),
      .in_side    (sd_ff[CW+1]),
      .out_strobe (rsp_strobe),
      .out_rsp    (rsp_data)
   );
endmodule

// ===== tb/ray_plane_intersect_tb.sv =====
// self-checking testbench for the ray/plane intersection unit
module ray_plane_intersect_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = rpi_pkg::CW;
   localparam int FB = rpi_pkg::FB;
   localparam int IW = rpi_pkg::IW;
   localparam int LATENCY = CW + 7;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   rpi_pkg::req_type req_data;
   logic rsp_strobe;
   rpi_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [IW-1:0] csr_index;
   logic [CW-1:0] csr_data;

   // plane copy held by the predictor
   logic signed [CW-1:0] pl_nx, pl_ny, pl_nz, pl_d;
   logic [CW-2:0] pl_thr;

   rpi_pkg::rsp_type pending_rsp[$];
   int errors;
   int send_idle_pct;

   ray_plane_intersect dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic signed [CW-1:0] clamp_coord(input logic signed [255:0] v,
                                                       inout logic ov);
      logic signed [255:0] hi_lim, lo_lim;
      hi_lim = (256'sd1 <<< (CW - 1)) - 1;
      lo_lim = -(256'sd1 <<< (CW - 1));
      if (v > hi_lim) begin
         ov = 1'b1;
         return hi_lim[CW-1:0];
      end
      if (v < lo_lim) begin
         ov = 1'b1;
         return lo_lim[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   function automatic rpi_pkg::rsp_type predict_plane(input rpi_pkg::req_type rq);
      rpi_pkg::rsp_type r;
      logic signed [255:0] pn, dn, dq, num, q, t, h, mag, thr, adn, hi_lim;
      logic signed [255:0] org[3], dir[3];
      logic ov;
      logic signed [CW-1:0] tc;
      r = '0;
      ov = 1'b0;
      org[0] = rq.origin_x; org[1] = rq.origin_y; org[2] = rq.origin_z;
      dir[0] = rq.dir_x;    dir[1] = rq.dir_y;    dir[2] = rq.dir_z;
      pn = org[0] * pl_nx + org[1] * pl_ny + org[2] * pl_nz;
      dq = $signed(pl_d) * (256'sd1 <<< FB);
      if (rq.command) begin
         mag = pn + dq;
         if (mag < 0) mag = -mag;
         mag = mag >>> FB;
         hi_lim = (256'sd1 <<< (CW - 1)) - 1;
         if (mag > hi_lim) begin
            ov = 1'b1;
            mag = hi_lim;
         end
         r.distance = mag[CW-2:0];
         r.overflow = ov;
         return r;
      end
      dn = dir[0] * pl_nx + dir[1] * pl_ny + dir[2] * pl_nz;
      thr = $signed({1'b0, pl_thr}) * (256'sd1 <<< FB);
      adn = (dn < 0) ? -dn : dn;
      if (adn <= thr) return r;
      num = (dq - pn) * (256'sd1 <<< FB);
      // signed division truncates toward zero
      q = num / dn;
      tc = clamp_coord(q, ov);
      t = tc;
      r.hit = 1'b1;
      h = org[0] + ((t * dir[0]) >>> FB);
      r.hit_x = clamp_coord(h, ov);
      h = org[1] + ((t * dir[1]) >>> FB);
      r.hit_y = clamp_coord(h, ov);
      h = org[2] + ((t * dir[2]) >>> FB);
      r.hit_z = clamp_coord(h, ov);
      r.overflow = ov;
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      rpi_pkg::rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected word %h", rsp_data);
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.hit !== exp_rsp.hit) begin
               $error("hit exp %0d got %0d", exp_rsp.hit, rsp_data.hit);
               errors++;
            end
            if (rsp_data.hit_x !== exp_rsp.hit_x) begin
               $error("hit_x exp %0d got %0d", exp_rsp.hit_x, rsp_data.hit_x);
               errors++;
            end
            if (rsp_data.hit_y !== exp_rsp.hit_y) begin
               $error("hit_y exp %0d got %0d", exp_rsp.hit_y, rsp_data.hit_y);
               errors++;
            end
            if (rsp_data.hit_z !== exp_rsp.hit_z) begin
               $error("hit_z exp %0d got %0d", exp_rsp.hit_z, rsp_data.hit_z);
               errors++;
            end
            if (rsp_data.distance !== exp_rsp.distance) begin
               $error("distance exp %0d got %0d", exp_rsp.distance, rsp_data.distance);
               errors++;
            end
            if (rsp_data.overflow !== exp_rsp.overflow) begin
               $error("overflow exp %0d got %0d", exp_rsp.overflow, rsp_data.overflow);
               errors++;
            end
         end
      end
   end

   // start stays high between back-to-back words, dropped while idling or draining
   task automatic send_word(input rpi_pkg::req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_plane(rq));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         rpi_pkg::REG_NORMAL_X:  pl_nx = val;
         rpi_pkg::REG_NORMAL_Y:  pl_ny = val;
         rpi_pkg::REG_NORMAL_Z:  pl_nz = val;
         rpi_pkg::REG_OFFSET_D:  pl_d = val;
         rpi_pkg::REG_THRESHOLD: pl_thr = val[CW-2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_plane(input logic [CW-1:0] nx, ny, nz, d, thr);
      write_reg(rpi_pkg::REG_NORMAL_X, nx);
      write_reg(rpi_pkg::REG_NORMAL_Y, ny);
      write_reg(rpi_pkg::REG_NORMAL_Z, nz);
      write_reg(rpi_pkg::REG_OFFSET_D, d);
      write_reg(rpi_pkg::REG_THRESHOLD, thr);
   endtask

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom();
         1: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
         2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return 32'($signed($urandom_range(400)) - 200) <<< FB
                         | 32'($urandom_range(65535));
      endcase
   endfunction

   function automatic rpi_pkg::req_type rand_word();
      rpi_pkg::req_type rq;
      rq.command = $urandom_range(3) == 0;
      rq.origin_x = rand_coord();
      rq.origin_y = rand_coord();
      rq.origin_z = rand_coord();
      rq.dir_x = rand_coord();
      rq.dir_y = rand_coord();
      rq.dir_z = rand_coord();
      return rq;
   endfunction

   task automatic test_reset_plane();
      rpi_pkg::req_type rq;
      // reset plane has a zero normal, so every ray is parallel
      rq = '0;
      rq.dir_x = 32'h0001_0000;
      send_word(rq);
      rq.command = 1'b1;
      send_word(rq);
      drain_results();
   endtask

   task automatic test_directed();
      rpi_pkg::req_type rq;
      load_plane(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0002_0000, 32'h0000_0100);
      // ray straight down onto y = 2
      rq = '0;
      rq.origin_y = 32'h000a_0000;
      rq.dir_y = 32'hffff_0000;
      send_word(rq);
      // ray along the plane, parallel
      rq.dir_y = 32'h0;
      rq.dir_x = 32'h0001_0000;
      send_word(rq);
      // direction dot exactly at the threshold stays parallel
      rq.dir_x = 32'h0;
      rq.dir_y = 32'h0000_0100;
      send_word(rq);
      rq.dir_y = 32'h0000_0101;
      send_word(rq);
      // huge t saturates
      rq.origin_y = 32'h7fff_ffff;
      rq.dir_y = 32'hffff_fe00;
      send_word(rq);
      rq.origin_x = 32'h8000_0000;
      rq.origin_y = 32'h8000_0000;
      rq.dir_x = 32'h7fff_ffff;
      rq.dir_y = 32'h7fff_ffff;
      rq.dir_z = 32'h8000_0000;
      send_word(rq);
      // distance queries, including one that saturates
      rq.command = 1'b1;
      rq.origin_y = 32'hfffd_0000;
      send_word(rq);
      rq.origin_y = 32'h7fff_ffff;
      send_word(rq);
      rq = '1;
      send_word(rq);
      rq.command = 1'b0;
      send_word(rq);
      drain_results();
      load_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
      rq = '0;
      rq.dir_x = 32'h0000_0001;
      send_word(rq);
      rq.command = 1'b1;
      rq.origin_z = 32'h7fff_ffff;
      send_word(rq);
      rq.command = 1'b0;
      rq.origin_x = 32'h8000_0000;
      rq.dir_x = 32'h8000_0000;
      rq.dir_y = 32'h7fff_ffff;
      send_word(rq);
      drain_results();
      load_plane(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      rq = '0;
      rq.dir_x = 32'h7fff_ffff;
      rq.dir_y = 32'h7fff_ffff;
      rq.dir_z = 32'h7fff_ffff;
      send_word(rq);
      rq.command = 1'b1;
      send_word(rq);
      drain_results();
   endtask

   task automatic test_random_phase(input int pct, input int count);
      send_idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         if (i % 90 == 0) begin
            drain_results();
            case ($urandom_range(2))
               // unit normals along an axis
               0: load_plane($urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000, 32'h0, 32'h0,
                             rand_coord(), $urandom_range(1024));
               1: load_plane(32'h0000_b505, 32'hffff_4afb, 32'h0, rand_coord(),
                             $urandom_range(1) ? 32'h0 : $urandom());
               default: load_plane(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                   $urandom_range(3) == 0 ? $urandom() : $urandom_range(64));
            endcase
            // unused index is ignored
            write_reg(3'd5 + 3'($urandom_range(2)), $urandom());
         end
         send_word(rand_word());
      end
      drain_results();
   endtask

   initial begin
      errors = 0;
      send_idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      pl_nx = '0;
      pl_ny = '0;
      pl_nz = '0;
      pl_d = '0;
      pl_thr = (CW-1)'(1);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_plane();
      test_directed();
      test_random_phase(26, 270);
      test_random_phase(45, 270);
      test_random_phase(0, 270);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
